// ===== design/line_editor_word_wrap_top_macros.svh =====
// ----------------------------------------------------------------------------
// line editor assertion macros
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_WORD_WRAP_TOP_MACROS_SVH
`define LINE_EDITOR_WORD_WRAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LEW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LEW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LEW_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LEW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lew_pkg.sv =====
// ----------------------------------------------------------------------------
// line editor package
// shared types and constants of the line editor
// ----------------------------------------------------------------------------
package lew_pkg;

    localparam int SLOTS  = 2048;
    localparam int FILL_W = $clog2(SLOTS);
    localparam int ROW_W  = 11;
    localparam int COL_W  = 9;

    localparam logic [7:0] KEY_DEL    = 8'h7F;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_KILL   = 8'h15;
    localparam logic [7:0] KEY_WERASE = 8'h17;
    localparam logic [7:0] KEY_EOF    = 8'h04;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [6:0] SPACE_CH   = 7'd32;
    localparam logic [7:0] WIDTH_RESET = 8'd40;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_BELL = 2'd1;
    localparam logic [1:0] STAT_EXIT = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_BACK,
        OP_KILL,
        OP_WERASE,
        OP_EOF,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FILL_W-1:0] len;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_ERS_RD,
        S_ERS_CHK,
        S_LAY_RD,
        S_LAY_CHK,
        S_WRD_RD,
        S_WRD_CHK,
        S_WRD_FIT,
        S_WRD_WALK,
        S_DONE
    } state_t;

endpackage

// ===== design/lew_front.sv =====
// ----------------------------------------------------------------------------
// line editor front
// decodes each key byte into an edit command
// ----------------------------------------------------------------------------
module lew_front (
    input  logic          s_tvalid,
    input  logic [7:0]    s_tdata,
    input  logic          q_full,
    output logic          s_tready,
    output logic          q_push,
    output lew_pkg::cmd_t q_data
);

    assign s_tready    = !q_full;
    assign q_push      = s_tvalid && !q_full;
    assign q_data.ch   = s_tdata[6:0];

    always_comb
    begin
        if (s_tdata == lew_pkg::KEY_EOF)
            q_data.op = lew_pkg::OP_EOF;
        else if (s_tdata == lew_pkg::KEY_DEL || s_tdata == lew_pkg::KEY_BS)
            q_data.op = lew_pkg::OP_BACK;
        else if (s_tdata == lew_pkg::KEY_KILL)
            q_data.op = lew_pkg::OP_KILL;
        else if (s_tdata == lew_pkg::KEY_WERASE)
            q_data.op = lew_pkg::OP_WERASE;
        else if (s_tdata < lew_pkg::PRINT_LO || s_tdata > lew_pkg::PRINT_HI)
            q_data.op = lew_pkg::OP_BAD;
        else
            q_data.op = lew_pkg::OP_APPEND;
    end

endmodule

// ===== design/lew_queue.sv =====
// ----------------------------------------------------------------------------
// line editor command queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lew_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lew_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output lew_pkg::cmd_t pop_data
);

    lew_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== design/lew_back.sv =====
// ----------------------------------------------------------------------------
// line editor back
// applies edits to the character store and walks the wrapped layout
// ----------------------------------------------------------------------------
module lew_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    line_width,
    input  logic          q_valid,
    input  lew_pkg::cmd_t q_data,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output lew_pkg::res_t res_data
);

    localparam int FW = lew_pkg::FILL_W;

    logic [6:0]    mem [lew_pkg::SLOTS];
    logic [6:0]    rd_data_reg;
    logic [FW-1:0] rd_addr;
    logic          wr_en;

    lew_pkg::state_t state_reg, state_next;
    lew_pkg::cmd_t   cmd_reg, cmd_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [FW-1:0]   idx_reg, idx_next;
    logic [FW-1:0]   scan_reg, scan_next;
    logic [FW-1:0]   wlen_reg, wlen_next;
    logic [lew_pkg::ROW_W-1:0] row_reg, row_next;
    logic [lew_pkg::COL_W-1:0] col_reg, col_next;
    logic [1:0]      status_reg, status_next;
    logic            phase_reg, phase_next;

    logic [lew_pkg::COL_W-1:0] width_ext;
    logic                      col_full;
    logic                      rd_space;

    assign width_ext = {1'b0, line_width};
    assign col_full  = (col_reg >= width_ext);
    assign rd_space  = (rd_data_reg == lew_pkg::SPACE_CH);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[fill_reg] <= cmd_reg.ch;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lew_pkg::S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        scan_reg   <= scan_next;
        wlen_reg   <= wlen_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        status_reg <= status_next;
        phase_reg  <= phase_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        scan_next   = scan_reg;
        wlen_next   = wlen_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        status_next = status_reg;
        phase_next  = phase_reg;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        q_pop       = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            lew_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    state_next = lew_pkg::S_EXEC;
                end
            end
            lew_pkg::S_EXEC:
            begin
                status_next = lew_pkg::STAT_DONE;
                idx_next    = '0;
                row_next    = '0;
                col_next    = '0;
                state_next  = lew_pkg::S_LAY_RD;
                unique case (cmd_reg.op)
                    lew_pkg::OP_APPEND:
                    begin
                        if (fill_reg == FW'(lew_pkg::SLOTS - 1))
                            status_next = lew_pkg::STAT_BELL;
                        else
                        begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    lew_pkg::OP_BACK:
                    begin
                        if (fill_reg == '0)
                            status_next = lew_pkg::STAT_BELL;
                        else
                            fill_next = fill_reg - 1'b1;
                    end
                    lew_pkg::OP_KILL:
                    begin
                        if (fill_reg == '0)
                            status_next = lew_pkg::STAT_BELL;
                        else
                            fill_next = '0;
                    end
                    lew_pkg::OP_WERASE:
                    begin
                        if (fill_reg == '0)
                            status_next = lew_pkg::STAT_BELL;
                        else
                        begin
                            idx_next   = fill_reg;
                            phase_next = 1'b0;
                            state_next = lew_pkg::S_ERS_RD;
                        end
                    end
                    lew_pkg::OP_EOF:
                    begin
                        status_next = (fill_reg == '0) ? lew_pkg::STAT_EXIT
                                                       : lew_pkg::STAT_BELL;
                    end
                    default:
                    begin
                        status_next = lew_pkg::STAT_BELL;
                    end
                endcase
            end
            lew_pkg::S_ERS_RD:
            begin
                rd_addr = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    fill_next  = '0;
                    state_next = lew_pkg::S_LAY_RD;
                end
                else
                    state_next = lew_pkg::S_ERS_CHK;
            end
            lew_pkg::S_ERS_CHK:
            begin
                if (!rd_space || !phase_reg)
                begin
                    // trailing spaces first, then the word itself
                    if (!rd_space)
                        phase_next = 1'b1;
                    idx_next   = idx_reg - 1'b1;
                    state_next = lew_pkg::S_ERS_RD;
                end
                else
                begin
                    fill_next  = idx_reg;
                    idx_next   = '0;
                    state_next = lew_pkg::S_LAY_RD;
                end
            end
            lew_pkg::S_LAY_RD:
            begin
                if (idx_reg == fill_reg)
                    state_next = lew_pkg::S_DONE;
                else
                    state_next = lew_pkg::S_LAY_CHK;
            end
            lew_pkg::S_LAY_CHK:
            begin
                if (rd_space)
                begin
                    if (col_full)
                    begin
                        row_next = row_reg + 1'b1;
                        col_next = lew_pkg::COL_W'(1);
                    end
                    else
                        col_next = col_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = lew_pkg::S_LAY_RD;
                end
                else
                begin
                    scan_next  = idx_reg + 1'b1;
                    wlen_next  = FW'(1);
                    state_next = lew_pkg::S_WRD_RD;
                end
            end
            lew_pkg::S_WRD_RD:
            begin
                rd_addr = scan_reg;
                if (scan_reg == fill_reg)
                    state_next = lew_pkg::S_WRD_FIT;
                else
                    state_next = lew_pkg::S_WRD_CHK;
            end
            lew_pkg::S_WRD_CHK:
            begin
                if (!rd_space)
                begin
                    scan_next  = scan_reg + 1'b1;
                    wlen_next  = wlen_reg + 1'b1;
                    state_next = lew_pkg::S_WRD_RD;
                end
                else
                    state_next = lew_pkg::S_WRD_FIT;
            end
            lew_pkg::S_WRD_FIT:
            begin
                // one extra bit so a long word cannot wrap the sum
                if (((FW+1)'(col_reg) + (FW+1)'(wlen_reg) > (FW+1)'(line_width))
                    && col_reg != '0)
                begin
                    row_next = row_reg + 1'b1;
                    col_next = '0;
                end
                state_next = lew_pkg::S_WRD_WALK;
            end
            lew_pkg::S_WRD_WALK:
            begin
                if (col_full)
                begin
                    row_next = row_reg + 1'b1;
                    col_next = lew_pkg::COL_W'(1);
                end
                else
                    col_next = col_reg + 1'b1;
                idx_next  = idx_reg + 1'b1;
                wlen_next = wlen_reg - 1'b1;
                if (wlen_reg == FW'(1))
                    state_next = lew_pkg::S_LAY_RD;
            end
            lew_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = lew_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lew_pkg::S_IDLE;
            end
        endcase
    end

    assign res_data.status = status_reg;
    assign res_data.len    = fill_reg;
    assign res_data.row    = row_reg;
    assign res_data.col    = col_reg + 1'b1;

endmodule

// ===== design/line_editor_word_wrap_top.sv =====
// ----------------------------------------------------------------------------
// line editor with word wrap
// keyboard byte in, edit status, length and wrapped end cursor out
// ----------------------------------------------------------------------------
// One key byte per transfer edits a text buffer whose cursor is always at the
// end; every key gives exactly one result transfer with the status, the text
// length and the row and column of the end cursor in a layout wrapped at
// line_width columns. The front decodes the key and parks it in a two-entry
// queue; the back applies the edit to a character store with one write and
// one read port and then rewalks the whole text from the start, before the
// result passes through the output register. Word erase first steps back
// over the removed characters, reading each. The store needs no clearing
// after reset. line_width is written through cfg_we/cfg_wdata; the user must
// do so only while the block is idle, the block itself does not enforce it.
`include "line_editor_word_wrap_top_macros.svh"

module line_editor_word_wrap_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write, line_width
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // key input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_byte[7:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], text_length[12:2],
                                   // cursor_row[23:13], cursor_col[32:24], zero
);

    logic [7:0]    line_width_reg;

    logic          q_full;
    logic          q_push;
    lew_pkg::cmd_t q_in;
    logic          q_valid;
    logic          q_pop;
    lew_pkg::cmd_t q_out;

    logic          res_valid;
    logic          res_ready;
    lew_pkg::res_t res_data;

    logic          m_tvalid_reg;
    lew_pkg::res_t out_reg;

    // width register, reset to 40 columns
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_width_reg <= lew_pkg::WIDTH_RESET;
        else if (cfg_we)
            line_width_reg <= cfg_wdata;
    end

    // front: key decode
    lew_front u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .s_tready (s_tready),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // decoupling queue
    lew_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    // back: edit and layout walk
    lew_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (line_width_reg),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

    // output register, loads when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (res_ready)
            m_tvalid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_reg <= res_data;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, out_reg.col, out_reg.row, out_reg.len, out_reg.status};

    // the end cursor column counts from one
    `LEW_ASSERT_SAME(a_col_nonzero, clk, rst_n, m_tvalid, m_tdata[32:24] != 9'd0)
    // status code three is never produced
    `LEW_ASSERT_SAME(a_status_code, clk, rst_n, m_tvalid, m_tdata[1:0] != 2'd3)
    // exit is only reported for an empty buffer
    `LEW_ASSERT_SAME(a_exit_empty, clk, rst_n,
        m_tvalid && m_tdata[1:0] == lew_pkg::STAT_EXIT, m_tdata[12:2] == 11'd0)
    // a finished result lands in the output register
    `LEW_ASSERT_NEXT(a_res_load, clk, rst_n, res_valid && res_ready, m_tvalid)

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// line editor word wrap testbench
// drives key transfers under random idling, predicts status, length and
// wrapped end cursor per key, and checks every result transfer in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [8:0]  col;
        logic [10:0] row;
        logic [10:0] text_len;
        logic [1:0]  status;
    } edit_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    line_editor_word_wrap_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow copy of the editor state
    logic [6:0]  text_shadow [0:lew_pkg::SLOTS-1];
    int unsigned text_fill;
    logic [7:0]  wrap_width;

    edit_result_t pending_results[$];
    int          error_count;
    int          keys_sent;
    int          results_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;

    localparam int QUIET_LIMIT = 200000;

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // end cursor of the wrapped layout
    function automatic void wrap_cursor(output int unsigned row, output int unsigned col);
        int unsigned i;
        int unsigned j;
        int unsigned w;
        i   = 0;
        row = 0;
        col = 0;
        w   = wrap_width;
        while (i < text_fill)
        begin
            if (text_shadow[i] == lew_pkg::SPACE_CH)
            begin
                if (col >= w)
                begin
                    row++;
                    col = 0;
                end
                col++;
                i++;
            end
            else
            begin
                j = i;
                while (j < text_fill && text_shadow[j] != lew_pkg::SPACE_CH)
                    j++;
                // word that does not fit moves down unless already at line start
                if (col + (j - i) > w && col > 0)
                begin
                    row++;
                    col = 0;
                end
                while (i < j)
                begin
                    if (col >= w)
                    begin
                        row++;
                        col = 0;
                    end
                    col++;
                    i++;
                end
            end
        end
        col = col + 1;
    endfunction

    // apply one key to the shadow state and queue the expected result
    function automatic void predict_edit(input logic [7:0] key);
        logic [1:0]   st;
        int unsigned  row;
        int unsigned  col;
        int unsigned  stop;
        edit_result_t r;
        st = lew_pkg::STAT_DONE;
        if (key == lew_pkg::KEY_EOF)
            st = (text_fill == 0) ? lew_pkg::STAT_EXIT : lew_pkg::STAT_BELL;
        else if (key == lew_pkg::KEY_DEL || key == lew_pkg::KEY_BS)
        begin
            if (text_fill > 0) text_fill--;
            else st = lew_pkg::STAT_BELL;
        end
        else if (key == lew_pkg::KEY_KILL)
        begin
            if (text_fill > 0) text_fill = 0;
            else st = lew_pkg::STAT_BELL;
        end
        else if (key == lew_pkg::KEY_WERASE)
        begin
            if (text_fill > 0)
            begin
                stop = text_fill;
                while (stop > 0 && text_shadow[stop-1] == lew_pkg::SPACE_CH) stop--;
                while (stop > 0 && text_shadow[stop-1] != lew_pkg::SPACE_CH) stop--;
                text_fill = stop;
            end
            else
                st = lew_pkg::STAT_BELL;
        end
        else if (key < lew_pkg::PRINT_LO || key > lew_pkg::PRINT_HI)
            st = lew_pkg::STAT_BELL;
        else if (text_fill + 1 >= lew_pkg::SLOTS)
            st = lew_pkg::STAT_BELL;
        else
        begin
            text_shadow[text_fill] = key[6:0];
            text_fill++;
        end
        wrap_cursor(row, col);
        r.status   = st;
        r.text_len = text_fill[10:0];
        r.row      = row[10:0];
        r.col      = col[8:0];
        pending_results.push_back(r);
    endfunction

    // one key transfer, with random sender idling
    task automatic send_key(input logic [7:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_edit(key);
        keys_sent++;
        @(negedge clk);
    endtask

    // wait until every result is back, then let the block settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // width change only while idle
    task automatic set_width(input logic [7:0] w);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we    <= 1'b0;
        wrap_width = w;
    endtask

    task automatic type_word(input int unsigned len);
        repeat (len) send_key(8'(8'd33 + $urandom_range(93)));
    endtask

    // receiver stall and result checks
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        edit_result_t got;
        edit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[32:0];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.text_len !== want.text_len)
                begin
                    $error("text_length expected %0d got %0d", want.text_len, got.text_len);
                    error_count++;
                end
                if (got.row !== want.row)
                begin
                    $error("cursor_row expected %0d got %0d", want.row, got.row);
                    error_count++;
                end
                if (got.col !== want.col)
                begin
                    $error("cursor_col expected %0d got %0d", want.col, got.col);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[line_editor_word_wrap_top] ERROR");
            $finish;
        end
    end

    // directed: extremes of the key byte, every key kind and the empty-buffer cases
    task automatic test_directed_keys;
        send_key(lew_pkg::KEY_BS);
        send_key(lew_pkg::KEY_DEL);
        send_key(lew_pkg::KEY_KILL);
        send_key(lew_pkg::KEY_WERASE);
        send_key(lew_pkg::KEY_EOF);
        send_key(8'h00);
        send_key(8'hFF);
        send_key(8'h80);
        send_key(lew_pkg::PRINT_LO);
        send_key(lew_pkg::PRINT_HI);
        send_key(8'h41);
        send_key(lew_pkg::PRINT_LO);
        send_key(8'h42);
        send_key(8'h43);
        send_key(lew_pkg::PRINT_LO);
        send_key(lew_pkg::PRINT_LO);
        send_key(lew_pkg::KEY_WERASE);
        send_key(lew_pkg::KEY_EOF);
        send_key(lew_pkg::KEY_BS);
        send_key(lew_pkg::KEY_DEL);
        send_key(lew_pkg::KEY_KILL);
        send_key(8'h1F);
        send_key(8'h7E);
    endtask

    // narrow widths: zero, one and a small one, with long words and spaces
    task automatic test_narrow_widths;
        set_width(8'd0);
        send_key(lew_pkg::PRINT_LO);
        type_word(3);
        send_key(lew_pkg::PRINT_LO);
        type_word(2);
        send_key(lew_pkg::KEY_KILL);
        set_width(8'd1);
        type_word(3);
        send_key(lew_pkg::PRINT_LO);
        send_key(lew_pkg::PRINT_LO);
        type_word(2);
        send_key(lew_pkg::KEY_WERASE);
        set_width(8'd5);
        type_word(5);
        send_key(lew_pkg::PRINT_LO);
        type_word(7);
        send_key(lew_pkg::KEY_KILL);
    endtask

    // random runs: mostly words and spaces with some edits and noise
    task automatic test_random_text(input int n, input int idle, input int stall);
        int k;
        int pick;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_key(8'(8'd33 + $urandom_range(93)));
            else if (pick < 72)
                send_key(lew_pkg::PRINT_LO);
            else if (pick < 78)
                send_key(($urandom_range(1) != 0) ? lew_pkg::KEY_DEL : lew_pkg::KEY_BS);
            else if (pick < 83)
                send_key(lew_pkg::KEY_WERASE);
            else if (pick < 85)
                send_key(lew_pkg::KEY_KILL);
            else if (pick < 87)
                send_key(lew_pkg::KEY_EOF);
            else
                send_key(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 8'd0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        m_tready       = 1'b0;
        text_fill      = 0;
        wrap_width     = lew_pkg::WIDTH_RESET;
        error_count    = 0;
        keys_sent      = 0;
        results_seen   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_keys();
        test_narrow_widths();
        set_width(8'd12);
        test_random_text(22, 0, 0);
        set_width(8'd7);
        test_random_text(22, 82, 0);
        set_width(8'd255);
        test_random_text(22, 0, 82);
        set_width(8'd20);
        test_random_text(22, 32, 32);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
        $display("covered %0d keys and %0d results over widths 0..255",
                 keys_sent, results_seen);
        $display("with every key kind and all idling phases");
        if (error_count == 0)
            $display("[line_editor_word_wrap_top] OK");
        else
            $display("[line_editor_word_wrap_top] ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/lew_pkg.sv
design/lew_front.sv
design/lew_queue.sv
design/lew_back.sv
design/line_editor_word_wrap_top.sv
tb/tb.sv
